// ===== sv/irdi_pkg.sv =====
// Shared types and constants for the IR ADC to distance interpolator.
// Used by the front end, the request queue, the divider back end and the top level.
// No dependencies.
`default_nettype none

package irdi_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int NUM_BREAKS   = 6;
    localparam int SEG_BITS     = $clog2(NUM_BREAKS);
    localparam int CFG_IDX_BITS = SEG_BITS;
    localparam int DIST_BITS    = 7;
    localparam int STEP_BITS    = 6;
    localparam int NUM_BITS     = SAMPLE_BITS + STEP_BITS;

    localparam int DIST_MIN  = 9;
    localparam int DIST_MAX  = 80;

    // Clamp windows: 102 percent of the far breakpoint, 98 percent of the near one.
    localparam int PCT_SCALE  = 100;
    localparam int FAR_PCT    = 102;
    localparam int NEAR_PCT   = 98;
    localparam int PCT_BITS   = 7;
    localparam int CLAMP_BITS = SAMPLE_BITS + PCT_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_B9  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_B15 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_B20 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_B30 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_B40 = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_B80 = CFG_IDX_BITS'(5);

    localparam logic [DIST_BITS-1:0] SEG_DIST [NUM_BREAKS] =
        '{7'd9, 7'd15, 7'd20, 7'd30, 7'd40, 7'd80};

    localparam logic [SAMPLE_BITS-1:0] BREAK_RESET [NUM_BREAKS] =
        '{SAMPLE_BITS'(3000), SAMPLE_BITS'(2100), SAMPLE_BITS'(1650),
          SAMPLE_BITS'(1150), SAMPLE_BITS'(900),  SAMPLE_BITS'(500)};

    // One division request for the back end: result = base + floor(+-num / den).
    typedef struct packed {
        logic [DIST_BITS-1:0]   base;
        logic                   neg;
        logic [NUM_BITS-1:0]    num_mag;
        logic [SAMPLE_BITS-1:0] den_mag;
    } seg_req_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic                nonempty;
    } q_status_t;

    function automatic logic [DIST_BITS-1:0] seg_base(input logic [SEG_BITS-1:0] seg);
        return SEG_DIST[seg];
    endfunction

    function automatic logic [STEP_BITS-1:0] seg_step(input logic [SEG_BITS-1:0] seg);
        logic [SEG_BITS-1:0] nxt;
        nxt = seg + SEG_BITS'(1);
        return STEP_BITS'(SEG_DIST[nxt] - SEG_DIST[seg]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/irdi_front.sv =====
// Front end: breakpoint registers, clamp checks, segment search and request build.
// Depends on irdi_pkg; pushes division requests into irdi_queue.
`default_nettype none

module irdi_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [irdi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [irdi_pkg::SAMPLE_BITS-1:0]   cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [irdi_pkg::SAMPLE_BITS-1:0]   adc_sample,
    input  wire irdi_pkg::q_status_t                q_status,
    output logic                                    push,
    output irdi_pkg::seg_req_t                      push_data
);
    import irdi_pkg::*;

    localparam logic [1:0] KIND_FAR  = 2'd0;
    localparam logic [1:0] KIND_NEAR = 2'd1;
    localparam logic [1:0] KIND_SEG  = 2'd2;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + STEP_BITS + 1;

    logic [SAMPLE_BITS-1:0] brk_reg [NUM_BREAKS];

    logic                   a_valid_reg, a_valid_next;
    logic [SAMPLE_BITS-1:0] a_s_reg;
    logic [SEG_BITS-1:0]    a_seg_reg, a_seg_next;
    logic [1:0]             a_kind_reg, a_kind_next;
    logic [SAMPLE_BITS-1:0] a_x0_reg, a_x0_next;
    logic [SAMPLE_BITS-1:0] a_x1_reg, a_x1_next;

    logic                   accept;
    logic [CNT_BITS:0]      credit_used;
    logic [CLAMP_BITS-1:0]  s_scaled, far_lim, near_lim;

    logic signed [DIFF_BITS-1:0] diff_num, diff_den;
    logic signed [PROD_BITS-1:0] prod, prod_abs;
    logic signed [DIFF_BITS-1:0] den_abs;

    // Requests in stage A or the queue each hold a queue slot.
    assign credit_used = (CNT_BITS + 1)'(q_status.count) + (CNT_BITS + 1)'(a_valid_reg);
    assign in_stall    = credit_used >= (CNT_BITS + 1)'(QUEUE_DEPTH);
    assign accept      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BREAKS; i++)
            begin
                brk_reg[i] <= BREAK_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_BITS'(NUM_BREAKS)))
        begin
            brk_reg[cfg_index] <= cfg_data;
        end
    end

    // Stage A: clamp checks and the three-step search over the breakpoints.
    always_comb
    begin
        s_scaled = CLAMP_BITS'(adc_sample) * CLAMP_BITS'(PCT_SCALE);
        far_lim  = CLAMP_BITS'(brk_reg[REG_B80]) * CLAMP_BITS'(FAR_PCT);
        near_lim = CLAMP_BITS'(brk_reg[REG_B9]) * CLAMP_BITS'(NEAR_PCT);

        if (brk_reg[REG_B20] > adc_sample)
        begin
            if (brk_reg[REG_B30] > adc_sample)
            begin
                a_seg_next = (brk_reg[REG_B40] > adc_sample) ? SEG_BITS'(4) : SEG_BITS'(3);
            end
            else
            begin
                a_seg_next = SEG_BITS'(2);
            end
        end
        else
        begin
            a_seg_next = (brk_reg[REG_B15] > adc_sample) ? SEG_BITS'(1) : SEG_BITS'(0);
        end

        if (s_scaled <= far_lim)
        begin
            a_kind_next = KIND_FAR;
        end
        else if (s_scaled >= near_lim)
        begin
            a_kind_next = KIND_NEAR;
        end
        else
        begin
            a_kind_next = KIND_SEG;
        end

        case (a_seg_next)
            SEG_BITS'(0):
            begin
                a_x0_next = brk_reg[REG_B9];
                a_x1_next = brk_reg[REG_B15];
            end
            SEG_BITS'(1):
            begin
                a_x0_next = brk_reg[REG_B15];
                a_x1_next = brk_reg[REG_B20];
            end
            SEG_BITS'(2):
            begin
                a_x0_next = brk_reg[REG_B20];
                a_x1_next = brk_reg[REG_B30];
            end
            SEG_BITS'(3):
            begin
                a_x0_next = brk_reg[REG_B30];
                a_x1_next = brk_reg[REG_B40];
            end
            default:
            begin
                a_x0_next = brk_reg[REG_B40];
                a_x1_next = brk_reg[REG_B80];
            end
        endcase

        a_valid_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_s_reg    <= adc_sample;
            a_seg_reg  <= a_seg_next;
            a_kind_reg <= a_kind_next;
            a_x0_reg   <= a_x0_next;
            a_x1_reg   <= a_x1_next;
        end
    end

    // Stage B: segment differences, scale by the distance step, split into sign and magnitude.
    always_comb
    begin
        diff_num = $signed({1'b0, a_x0_reg}) - $signed({1'b0, a_s_reg});
        diff_den = $signed({1'b0, a_x0_reg}) - $signed({1'b0, a_x1_reg});
        prod     = PROD_BITS'(diff_num) * $signed(PROD_BITS'({1'b0, seg_step(a_seg_reg)}));
        prod_abs = prod[PROD_BITS-1] ? -prod : prod;
        den_abs  = diff_den[DIFF_BITS-1] ? -diff_den : diff_den;

        push_data.base    = seg_base(a_seg_reg);
        push_data.neg     = prod[PROD_BITS-1] ^ diff_den[DIFF_BITS-1];
        push_data.num_mag = prod_abs[NUM_BITS-1:0];
        push_data.den_mag = den_abs[SAMPLE_BITS-1:0];

        // Clamps and a flat segment become a zero quotient around a fixed base.
        if (a_kind_reg == KIND_FAR)
        begin
            push_data.base = DIST_BITS'(DIST_MAX);
        end
        else if (a_kind_reg == KIND_NEAR)
        begin
            push_data.base = DIST_BITS'(DIST_MIN);
        end

        if ((a_kind_reg != KIND_SEG) || (diff_den == '0))
        begin
            push_data.neg     = 1'b0;
            push_data.num_mag = '0;
            push_data.den_mag = SAMPLE_BITS'(1);
        end
    end

    assign push = a_valid_reg;

endmodule

`default_nettype wire

// ===== sv/irdi_queue.sv =====
// Short request queue between the front end and the divider back end.
// Depends on irdi_pkg for the request type and depth.
`default_nettype none

module irdi_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire irdi_pkg::seg_req_t   push_data,
    input  wire logic                 pop,
    output irdi_pkg::q_status_t       status,
    output irdi_pkg::seg_req_t        head_data
);
    import irdi_pkg::*;

    seg_req_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign status.count    = cnt_reg;
    assign status.nonempty = cnt_reg != '0;
    assign head_data       = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/irdi_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage, then floor
// correction, saturation to 9..80 and the output register. Depends on irdi_pkg.
`default_nettype none

module irdi_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire irdi_pkg::q_status_t              q_status,
    input  wire irdi_pkg::seg_req_t               q_data,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [irdi_pkg::DIST_BITS-1:0]        distance_cm
);
    import irdi_pkg::*;

    localparam int WIDE_BITS = NUM_BITS + 2;

    logic [NUM_BITS:0]      st_v_reg, st_v_next;
    logic [DIST_BITS-1:0]   st_base_reg [NUM_BITS+1];
    logic [DIST_BITS-1:0]   st_base_next [NUM_BITS+1];
    logic                   st_neg_reg [NUM_BITS+1];
    logic                   st_neg_next [NUM_BITS+1];
    logic [SAMPLE_BITS-1:0] st_den_reg [NUM_BITS+1];
    logic [SAMPLE_BITS-1:0] st_den_next [NUM_BITS+1];
    logic [SAMPLE_BITS-1:0] st_rem_reg [NUM_BITS+1];
    logic [SAMPLE_BITS-1:0] st_rem_next [NUM_BITS+1];
    logic [NUM_BITS-1:0]    st_nq_reg [NUM_BITS+1];
    logic [NUM_BITS-1:0]    st_nq_next [NUM_BITS+1];
    logic [SAMPLE_BITS:0]   rem_sh [NUM_BITS];
    logic [SAMPLE_BITS:0]   rem_dif [NUM_BITS];
    logic                   q_bit [NUM_BITS];

    logic                   adv;
    logic                   out_valid_reg, out_valid_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;

    logic                        rem_nz;
    logic [WIDE_BITS-1:0]        q_ext;
    logic signed [WIDE_BITS-1:0] delta, dist_wide;

    // The whole back end moves together whenever the output register can take a result.
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = q_status.nonempty && adv;

    always_comb
    begin
        st_v_next[0]    = q_pop;
        st_base_next[0] = q_data.base;
        st_neg_next[0]  = q_data.neg;
        st_den_next[0]  = q_data.den_mag;
        st_rem_next[0]  = '0;
        st_nq_next[0]   = q_data.num_mag;

        // Each stage shifts one numerator bit into the remainder and one quotient bit in.
        for (int k = 0; k < NUM_BITS; k++)
        begin
            rem_sh[k]  = {st_rem_reg[k], st_nq_reg[k][NUM_BITS-1]};
            rem_dif[k] = rem_sh[k] - {1'b0, st_den_reg[k]};
            q_bit[k]   = rem_sh[k] >= {1'b0, st_den_reg[k]};

            st_v_next[k+1]    = st_v_reg[k];
            st_base_next[k+1] = st_base_reg[k];
            st_neg_next[k+1]  = st_neg_reg[k];
            st_den_next[k+1]  = st_den_reg[k];
            st_rem_next[k+1]  = q_bit[k] ? rem_dif[k][SAMPLE_BITS-1:0]
                                         : rem_sh[k][SAMPLE_BITS-1:0];
            st_nq_next[k+1]   = {st_nq_reg[k][NUM_BITS-2:0], q_bit[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_v_reg <= '0;
        end
        else if (adv)
        begin
            st_v_reg <= st_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NUM_BITS; k++)
            begin
                st_base_reg[k] <= st_base_next[k];
                st_neg_reg[k]  <= st_neg_next[k];
                st_den_reg[k]  <= st_den_next[k];
                st_rem_reg[k]  <= st_rem_next[k];
                st_nq_reg[k]   <= st_nq_next[k];
            end
        end
    end

    // A negative quotient with a remainder rounds one further down (floor).
    always_comb
    begin
        rem_nz    = st_rem_reg[NUM_BITS] != '0;
        q_ext     = WIDE_BITS'(st_nq_reg[NUM_BITS]);
        delta     = st_neg_reg[NUM_BITS] ? -($signed(q_ext) + $signed(WIDE_BITS'(rem_nz)))
                                         : $signed(q_ext);
        dist_wide = $signed(WIDE_BITS'(st_base_reg[NUM_BITS])) + delta;

        if (dist_wide < $signed(WIDE_BITS'(DIST_MIN)))
        begin
            dist_next = DIST_BITS'(DIST_MIN);
        end
        else if (dist_wide > $signed(WIDE_BITS'(DIST_MAX)))
        begin
            dist_next = DIST_BITS'(DIST_MAX);
        end
        else
        begin
            dist_next = dist_wide[DIST_BITS-1:0];
        end

        out_valid_next = st_v_reg[NUM_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance_cm = dist_reg;

endmodule

`default_nettype wire

// ===== sv/ir_adc_to_distance_interp.sv =====
// IR range sensor ADC sample to distance in centimeters, piecewise linear.
// Instantiates irdi_front, irdi_queue and irdi_back; uses irdi_pkg.
//
// Usage: the input channel carries one adc_sample per request (in_valid / in_stall),
// the output channel one distance_cm per request (out_valid / out_stall). A request
// is taken at a rising edge with valid high and stall low. Six breakpoint registers
// (9, 15, 20, 30, 40 and 80 cm) are written through cfg_we / cfg_index / cfg_data
// while the block is idle; indexes past the last register are ignored.
// Throughput is one request per cycle while neither in_stall nor out_stall holds
// the flow. An accepted request passes the stage A register, the queue and the divider
// pipeline, which produces one quotient bit per stage, before reaching the output register.
// When the receiver stalls, the output register holds its result and the divider
// pipeline freezes; the four-entry queue behind the front end absorbs requests in
// flight, and in_stall rises once every queue slot is spoken for.
// Reset loads the breakpoint defaults and empties the pipeline and the queue.
`default_nettype none

module ir_adc_to_distance_interp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [irdi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [irdi_pkg::SAMPLE_BITS-1:0]   cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [irdi_pkg::SAMPLE_BITS-1:0]   adc_sample,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [irdi_pkg::DIST_BITS-1:0]          distance_cm
);
    import irdi_pkg::*;

    q_status_t q_status;
    seg_req_t  push_data;
    seg_req_t  head_data;
    logic      push;
    logic      q_pop;

    irdi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    irdi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .status    (q_status),
        .head_data (head_data)
    );

    irdi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (head_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_cm (distance_cm)
    );

    // The credit check at the input must keep the queue from overflowing.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("request queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.count != '0)
        else $error("pop from an empty request queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |-> q_status.count < CNT_BITS'(QUEUE_DEPTH))
        else $error("push into a full request queue");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance_cm >= DIST_BITS'(DIST_MIN)) &&
                      (distance_cm <= DIST_BITS'(DIST_MAX)))
        else $error("distance out of the saturated range");

endmodule

`default_nettype wire

// ===== dv/irdi_distance_checker.sv =====
`timescale 1ns / 1ps
// Checker for the IR ADC to distance interpolator: follows the breakpoint writes, predicts
// the distance for every accepted sample and compares it with every accepted output.
// Depends on irdi_pkg.

module irdi_distance_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [irdi_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [irdi_pkg::SAMPLE_BITS-1:0]  cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [irdi_pkg::SAMPLE_BITS-1:0]  adc_sample,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [irdi_pkg::DIST_BITS-1:0]    distance_cm,
    output int                                outstanding,
    output int                                fail_count
);
    import irdi_pkg::*;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [DIST_BITS-1:0]   distance;
    } dist_entry_t;

    logic [SAMPLE_BITS-1:0] breaks_q [NUM_BREAKS];
    dist_entry_t            pending_distances [$];

    function automatic longint anchor_cm(input int k);
        case (k)
            0: return 9;
            1: return 15;
            2: return 20;
            3: return 30;
            4: return 40;
            default: return 80;
        endcase
    endfunction

    // Piecewise linear lookup with the clamp windows, the fixed three-step search and
    // a floored quotient; the sum is saturated to the distance range.
    function automatic logic [DIST_BITS-1:0] predict_distance(input logic [SAMPLE_BITS-1:0] raw);
        longint s, x0, x1, den, num, q, d;
        int     lo, hi, mid;
        s  = raw;
        lo = 0;
        hi = NUM_BREAKS - 1;
        if (100 * s <= 102 * longint'(breaks_q[NUM_BREAKS-1])) begin
            d = DIST_MAX;
        end
        else if (100 * s >= 98 * longint'(breaks_q[0])) begin
            d = DIST_MIN;
        end
        else begin
            while (lo + 1 < hi) begin
                mid = lo + (hi - lo) / 2;
                if (longint'(breaks_q[mid]) > s)
                    lo = mid;
                else
                    hi = mid;
            end
            x0  = breaks_q[lo];
            x1  = breaks_q[lo+1];
            den = x0 - x1;
            if (den == 0) begin
                d = anchor_cm(lo);
            end
            else begin
                num = (anchor_cm(lo + 1) - anchor_cm(lo)) * (x0 - s);
                q   = num / den;
                if ((num % den != 0) && ((num < 0) != (den < 0)))
                    q = q - 1;
                d = anchor_cm(lo) + q;
            end
        end
        if (d < DIST_MIN)
            d = DIST_MIN;
        if (d > DIST_MAX)
            d = DIST_MAX;
        return d[DIST_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dist_entry_t want;
        int          pushed;
        int          popped;
        int          fails;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BREAKS; i++)
                breaks_q[i] <= BREAK_RESET[i];
            pending_distances.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            fails  = 0;
            if (cfg_we && cfg_index < NUM_BREAKS)
                breaks_q[cfg_index] <= cfg_data;
            if (out_valid && !out_stall)
            begin
                if (pending_distances.size() == 0)
                begin
                    fails = 1;
                    if (fail_count < 10)
                        $display("%0t: distance_cm=%0d with no request waiting", $time,
                                 distance_cm);
                end
                else
                begin
                    want   = pending_distances.pop_front();
                    popped = 1;
                    if (distance_cm !== want.distance)
                    begin
                        fails = 1;
                        if (fail_count < 10)
                            $display("%0t: sample %0d: distance_cm expected %0d, got %0d",
                                     $time, want.sample, want.distance, distance_cm);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want.sample   = adc_sample;
                want.distance = predict_distance(adc_sample);
                pending_distances.push_back(want);
                pushed = 1;
            end
            outstanding <= outstanding + pushed - popped;
            fail_count  <= fail_count + fails;
        end
    end

endmodule

// ===== dv/ir_adc_to_distance_interp_test.sv =====
`timescale 1ns / 1ps
// Testbench top for ir_adc_to_distance_interp: clock, reset, breakpoint setups, sample
// requests with random gaps, output stalls, watchdog and verdict.
// Depends on irdi_pkg, irdi_distance_checker and the block itself.

module ir_adc_to_distance_interp_test;
    import irdi_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 110;
    localparam int FLAT_ITEMS    = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_PAST_LAST = CFG_IDX_BITS'(NUM_BREAKS);
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_INDEX = '1;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
    logic [SAMPLE_BITS-1:0]  cfg_data   = '0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic [SAMPLE_BITS-1:0]  adc_sample = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic [DIST_BITS-1:0]    distance_cm;

    int   outstanding;
    int   fail_count;
    int   idle_cycles;
    logic gap_free     = 1'b0;
    logic hold_off_req = 1'b0;

    logic [SAMPLE_BITS-1:0] break_set [NUM_BREAKS];

    ir_adc_to_distance_interp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_cm (distance_cm)
    );

    irdi_distance_checker distance_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_cm (distance_cm),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Most samples land near a breakpoint or a clamp edge, where the arithmetic turns.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 45)
            v = $urandom_range(0, 4095);
        else if (r < 80)
            v = int'(break_set[$urandom_range(0, NUM_BREAKS - 1)]) + $urandom_range(0, 24) - 12;
        else if (r < 88)
            v = int'(break_set[NUM_BREAKS-1]) * 102 / 100 + $urandom_range(0, 2) - 1;
        else if (r < 96)
            v = int'(break_set[0]) * 98 / 100 + $urandom_range(0, 2) - 1;
        else
            v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        in_valid   <= 1'b1;
        adc_sample <= value;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every request in flight has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Indexes past the last register go out last, so any aliasing would show.
    task automatic load_breaks();
        write_reg(REG_B9,  break_set[REG_B9]);
        write_reg(REG_B15, break_set[REG_B15]);
        write_reg(REG_B20, break_set[REG_B20]);
        write_reg(REG_B30, break_set[REG_B30]);
        write_reg(REG_B40, break_set[REG_B40]);
        write_reg(REG_B80, break_set[REG_B80]);
        write_reg(REG_PAST_LAST, SAMPLE_BITS'($urandom_range(0, 4095)));
        write_reg(REG_TOP_INDEX, SAMPLE_BITS'($urandom_range(0, 4095)));
        cfg_we <= 1'b0;
    endtask

    task automatic fill_descending(input int first, input int stop);
        for (int k = first; k <= stop; k++)
            break_set[k] = break_set[k-1] - SAMPLE_BITS'($urandom_range(0, break_set[k-1] / 3));
    endtask

    initial
    begin : stall_gen
        int pick;
        int span;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall    <= 1'b1;
                hold_off_req <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    out_stall <= 1'b0;
                    span = $urandom_range(30, 120);
                end
                else if (pick < 60)
                begin
                    out_stall <= 1'b0;
                    span = $urandom_range(1, 6);
                end
                else if (pick < 95)
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(1, 4);
                end
                else
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(15, 60);
                end
                // A pending long hold cuts the current span short.
                for (int c = 0; c < span && !hold_off_req; c++)
                    @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ir_adc_to_distance_interp_test: FAIL");
        $finish;
    end

    initial
    begin : main_seq
        int count;
        for (int k = 0; k < NUM_BREAKS; k++)
            break_set[k] = BREAK_RESET[k];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default breakpoints: range ends, both clamp edges, breakpoints and segment interiors.
        offer_sample(12'd0);
        offer_sample(12'd4095);
        offer_sample(12'd510);
        offer_sample(12'd511);
        offer_sample(12'd2940);
        offer_sample(12'd2939);
        offer_sample(12'd2100);
        offer_sample(12'd2099);
        offer_sample(12'd1650);
        offer_sample(12'd1150);
        offer_sample(12'd900);
        offer_sample(12'd901);
        offer_sample(12'd2500);
        offer_sample(12'd1300);
        offer_sample(12'd700);
        offer_sample(12'hAAA);
        offer_sample(12'h555);

        // Equal neighboring breakpoints, where a segment has no width.
        drain_results();
        break_set = '{12'd3000, 12'd2100, 12'd2100, 12'd1150, 12'd1150, 12'd500};
        load_breaks();
        offer_sample(12'd2100);
        offer_sample(12'd1150);
        offer_sample(12'd1800);

        // Unsorted breakpoints take the same search and are saturated afterwards.
        drain_results();
        break_set = '{12'd1000, 12'd3000, 12'd200, 12'd4000, 12'd100, 12'd50};
        load_breaks();
        offer_sample(12'd300);
        offer_sample(12'd150);
        offer_sample(12'd60);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                0: for (int k = 0; k < NUM_BREAKS; k++) break_set[k] = BREAK_RESET[k];
                1: for (int k = 0; k < NUM_BREAKS; k++) break_set[k] = 12'd4095;
                2: for (int k = 0; k < NUM_BREAKS; k++) break_set[k] = 12'd0;
                3:
                begin
                    break_set[0] = 12'd4095;
                    fill_descending(1, NUM_BREAKS - 2);
                    break_set[NUM_BREAKS-1] = 12'd0;
                end
                5:
                    for (int k = 0; k < NUM_BREAKS; k++)
                        break_set[k] = SAMPLE_BITS'($urandom_range(0, 4095));
                default:
                begin
                    break_set[0] = SAMPLE_BITS'($urandom_range(1500, 4095));
                    fill_descending(1, NUM_BREAKS - 1);
                end
            endcase
            load_breaks();

            gap_free = (phase == 6) || ($urandom_range(0, 3) == 0);
            // Long receiver hold while requests keep coming, so the queue fills and
            // in_stall rises.
            if (phase == 6)
                hold_off_req <= 1'b1;
            count = (phase == 1 || phase == 2) ? FLAT_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < count; n++)
            begin
                if (phase == 7 && n == count / 2)
                    drain_results();
                offer_sample(pick_sample());
            end
            gap_free = 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ir_adc_to_distance_interp_test: PASS");
        else
            $display("ir_adc_to_distance_interp_test: FAIL");
        $finish;
    end

endmodule
